[rtl/core/qtss_pkg.sv]
// ----------------------------------------------------------------------------
// qtss_pkg
// Shared types and constants of the time slice scheduler: field widths,
// function and register codes, controller states, command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package qtss_pkg;

	// Payload field widths
	localparam int FUNC_W     = 2;
	localparam int PID_W      = 3;
	localparam int KIND_W     = 3;
	localparam int CYC_W      = 16;
	localparam int ENTRY_W    = KIND_W + CYC_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration reset values
	localparam logic             POLICY_RESET  = 1'b0;
	localparam logic [CYC_W-1:0] QUANTUM_RESET = 16'd50;

	// Policy codes
	localparam logic POLICY_RR   = 1'b0;
	localparam logic POLICY_SRPT = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM     = 2'd1;

	// Input function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_SLICE = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CLEAR,
		ST_SCAN,
		ST_DRAIN,
		ST_SERVE,
		ST_RESULT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic req_ready;
		logic start;
		logic do_load;
		logic do_clear;
		logic scan;
		logic do_serve;
		logic out_load;
	} ctrl_cmd_t;

	// Status seen by the controller
	typedef struct packed {
		logic  req_valid;
		func_t req_func;
		logic  scan_last;
		logic  out_free;
	} ctrl_sts_t;

	// One result beat
	typedef struct packed {
		logic              slice_valid;
		logic [PID_W-1:0]  slice_process;
		logic [KIND_W-1:0] slice_kind;
		logic [CYC_W-1:0]  slice_time;
		logic              task_finished;
		logic              all_done;
		logic              load_error;
	} res_t;

endpackage

`default_nettype wire

[rtl/core/qtss_if.sv]
// ----------------------------------------------------------------------------
// qtss_if
// Channel interfaces of the scheduler: request, result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtss_req_if;
	import qtss_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [PID_W-1:0]  process_id;
	logic [KIND_W-1:0] task_kind;
	logic [CYC_W-1:0]  task_cycles;

	modport source (output valid, func, process_id, task_kind, task_cycles, input ready);
	modport sink   (input valid, func, process_id, task_kind, task_cycles, output ready);
endinterface

interface qtss_rsp_if;
	import qtss_pkg::*;
	logic              valid;
	logic              ready;
	logic              slice_valid;
	logic [PID_W-1:0]  slice_process;
	logic [KIND_W-1:0] slice_kind;
	logic [CYC_W-1:0]  slice_time;
	logic              task_finished;
	logic              all_done;
	logic              load_error;

	modport source (output valid, slice_valid, slice_process, slice_kind, slice_time,
		task_finished, all_done, load_error, input ready);
	modport sink   (input valid, slice_valid, slice_process, slice_kind, slice_time,
		task_finished, all_done, load_error, output ready);
endinterface

interface qtss_cfg_if;
	import qtss_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/quantum_task_slice_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// quantum_task_slice_scheduler_unit
// Time slice scheduler with one task FIFO per process, round-robin or
// shortest-remaining selection, and a quantum-limited slice per request.
// ----------------------------------------------------------------------------
// Usage:
//   req : one beat per operation (func = load task, clear all, next slice).
//   rsp : exactly one result beat per request beat, in request order.
//   cfg : register writes (policy mode, quantum); always ready. The user must
//         write only while no request is in flight; the block does not enforce it.
// Request flow: one request is processed at a time. A slice request runs a
//   scan that reads one queue head per cycle from the task store RAM and
//   compares it, then serves the chosen head.
//   Requests are accepted only in the idle state, in the cycle after the prior
//   result is loaded into the result register.
// Reset: all queues empty, round-robin pointer 0, policy round robin,
//   quantum 50; the task store holds no valid data until loaded.
// Stall: the result register holds its beat while rsp.ready is low; the next
//   request is accepted and processed, and waits only to write its result.
// ----------------------------------------------------------------------------
`default_nettype none

module quantum_task_slice_scheduler_unit #(
	parameter int MAX_PROCESSES = 8,
	parameter int MAX_TASKS     = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	qtss_req_if.sink   req,
	qtss_rsp_if.source rsp,
	qtss_cfg_if.sink   cfg
);
	import qtss_pkg::*;

	logic             policy_q;
	logic [CYC_W-1:0] quantum_q;
	ctrl_cmd_t        cmd;
	ctrl_sts_t        sts;
	logic             scan_last;
	res_t             res;
	logic             out_valid_q;
	res_t             out_q;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POLICY_RESET;
			quantum_q <= QUANTUM_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_POLICY_MODE) begin
				policy_q <= cfg.data[0];
			end else if (cfg.index == CFG_QUANTUM) begin
				quantum_q <= cfg.data;
			end
		end
	end

	// controller status
	always_comb begin
		sts.req_valid = req.valid;
		sts.req_func  = func_t'(req.func);
		sts.scan_last = scan_last;
		sts.out_free  = !out_valid_q || rsp.ready;
	end

	assign req.ready = cmd.req_ready;

	qtss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	qtss_dp #(
		.MAX_PROCESSES (MAX_PROCESSES),
		.MAX_TASKS     (MAX_TASKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.policy_mode (policy_q),
		.quantum     (quantum_q),
		.process_id  (req.process_id),
		.task_kind   (req.task_kind),
		.task_cycles (req.task_cycles),
		.scan_last   (scan_last),
		.res         (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.slice_valid   = out_q.slice_valid;
	assign rsp.slice_process = out_q.slice_process;
	assign rsp.slice_kind    = out_q.slice_kind;
	assign rsp.slice_time    = out_q.slice_time;
	assign rsp.task_finished = out_q.task_finished;
	assign rsp.all_done      = out_q.all_done;
	assign rsp.load_error    = out_q.load_error;

	// one request in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");

	// an unfinished task stays queued
	a_unfinished_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.slice_valid && !rsp.task_finished |-> !rsp.all_done)
		else $error("all_done with a partially served task");

	// a partial slice always grants time
	a_partial_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.slice_valid && !rsp.task_finished |-> rsp.slice_time != '0)
		else $error("partial slice with zero time");

	// a refused load grants no slice
	a_err_no_slice: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.load_error |-> !rsp.slice_valid && !rsp.task_finished)
		else $error("load error together with a slice");

endmodule

`default_nettype wire

[rtl/core/qtss_ram.sv]
// ----------------------------------------------------------------------------
// qtss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qtss_ram #(
	parameter int WIDTH = 19,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/qtss_ctrl.sv]
// ----------------------------------------------------------------------------
// qtss_ctrl
// Scheduler sequencer: accepts a request, steps the datapath through load,
// clear or scan/serve, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qtss_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire qtss_pkg::ctrl_sts_t  sts,
	output qtss_pkg::ctrl_cmd_t       cmd
);
	import qtss_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.req_ready = 1'b1;
				if (sts.req_valid) begin
					cmd.start = 1'b1;
					unique case (sts.req_func)
						FUNC_LOAD:  state_d = ST_LOAD;
						FUNC_CLEAR: state_d = ST_CLEAR;
						FUNC_SLICE: state_d = ST_SCAN;
						FUNC_NOP:   state_d = ST_RESULT;
						default:    state_d = ST_RESULT;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.do_load = 1'b1;
				state_d     = ST_RESULT;
			end
			ST_CLEAR: begin
				cmd.do_clear = 1'b1;
				state_d      = ST_RESULT;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last head read returns and is compared
				state_d = ST_SERVE;
			end
			ST_SERVE: begin
				cmd.do_serve = 1'b1;
				state_d      = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/qtss_dp.sv]
// ----------------------------------------------------------------------------
// qtss_dp
// Scheduler datapath: per-process queue pointers, task store, head scan with
// best-candidate register, and slice computation.
// ----------------------------------------------------------------------------
`default_nettype none

module qtss_dp #(
	parameter int MAX_PROCESSES = 8,
	parameter int MAX_TASKS     = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire qtss_pkg::ctrl_cmd_t             cmd,
	input  wire logic                            policy_mode,
	input  wire logic [qtss_pkg::CYC_W-1:0]      quantum,
	input  wire logic [qtss_pkg::PID_W-1:0]      process_id,
	input  wire logic [qtss_pkg::KIND_W-1:0]     task_kind,
	input  wire logic [qtss_pkg::CYC_W-1:0]      task_cycles,
	output logic                                 scan_last,
	output qtss_pkg::res_t                       res
);
	import qtss_pkg::*;

	localparam int PW = $clog2(MAX_PROCESSES);
	localparam int HW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int AW = $clog2(MAX_PROCESSES * MAX_TASKS);
	localparam int TW = $clog2(MAX_PROCESSES * MAX_TASKS + 1);

	// captured request payload
	logic [PID_W-1:0]  pid_q;
	logic [KIND_W-1:0] kind_q;
	logic [CYC_W-1:0]  cyc_q;

	// queue state
	logic [HW-1:0] head_q  [MAX_PROCESSES];
	logic [CW-1:0] count_q [MAX_PROCESSES];
	logic [PW-1:0] rr_q;
	logic [TW-1:0] total_q;

	// scan state
	logic [PW-1:0]      scan_idx_q;
	logic [PW-1:0]      cand_p_s1;
	logic               cand_nz_s1;
	logic               cand_v_s1;
	logic               best_found_q;
	logic [PW-1:0]      best_p_q;
	logic [ENTRY_W-1:0] best_entry_q;

	res_t res_q;

	// combinational
	logic [PW:0]        rr_sum;
	logic [PW-1:0]      scan_p;
	logic [PW-1:0]      cur;
	logic [HW-1:0]      cur_head;
	logic [CW-1:0]      cur_count;
	logic [AW-1:0]      base_addr;
	logic [AW-1:0]      head_addr;
	logic [AW-1:0]      tail_addr;
	logic [HW:0]        tail_sum;
	logic [HW-1:0]      tail_pos;
	logic               load_ok;
	logic [ENTRY_W-1:0] rd_data;
	logic [CYC_W-1:0]   qv;
	logic [CYC_W-1:0]   best_rem;
	logic               fin;
	logic               take;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;

	// scan order: rotated from the round-robin pointer, or plain index order
	always_comb begin
		rr_sum = {1'b0, rr_q} + {1'b0, scan_idx_q};
		if (policy_mode == POLICY_RR) begin
			if (rr_sum >= (PW+1)'(MAX_PROCESSES)) begin
				scan_p = PW'(rr_sum - (PW+1)'(MAX_PROCESSES));
			end else begin
				scan_p = rr_sum[PW-1:0];
			end
		end else begin
			scan_p = scan_idx_q;
		end
	end

	// process whose queue is addressed this cycle
	always_comb begin
		priority if (cmd.do_serve) begin
			cur = best_p_q;
		end else if (cmd.scan) begin
			cur = scan_p;
		end else begin
			cur = PW'(pid_q);
		end
	end

	assign cur_head  = head_q[cur];
	assign cur_count = count_q[cur];
	assign base_addr = AW'(cur) * AW'(MAX_TASKS);
	assign head_addr = base_addr + AW'(cur_head);

	// tail slot, wrapped into the queue's ring
	always_comb begin
		tail_sum = {1'b0, cur_head} + (HW+1)'(cur_count);
		if (tail_sum >= (HW+1)'(MAX_TASKS)) begin
			tail_pos = HW'(tail_sum - (HW+1)'(MAX_TASKS));
		end else begin
			tail_pos = tail_sum[HW-1:0];
		end
	end
	assign tail_addr = base_addr + AW'(tail_pos);

	assign load_ok = (32'(pid_q) < MAX_PROCESSES) && (cur_count < CW'(MAX_TASKS));

	// slice arithmetic on the chosen head task
	assign qv       = (quantum == '0) ? CYC_W'(1) : quantum;
	assign best_rem = best_entry_q[CYC_W-1:0];
	assign fin      = (best_rem <= qv);

	// candidate compare as the head read returns
	assign take = cand_v_s1 && cand_nz_s1 &&
		(!best_found_q || (policy_mode == POLICY_SRPT && rd_data[CYC_W-1:0] < best_rem));

	assign scan_last = (scan_idx_q == PW'(MAX_PROCESSES - 1));

	// task store write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_addr;
		ram_wdata = {best_entry_q[ENTRY_W-1:CYC_W], best_rem - qv};
		if (cmd.do_load) begin
			ram_we    = load_ok;
			ram_waddr = tail_addr;
			ram_wdata = {kind_q, cyc_q};
		end else if (cmd.do_serve) begin
			ram_we = best_found_q && !fin;
		end
	end

	qtss_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_PROCESSES * MAX_TASKS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_addr),
		.rdata (rd_data)
	);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pid_q  <= process_id;
			kind_q <= task_kind;
			cyc_q  <= task_cycles;
		end
	end

	// queue pointers, counts and round-robin pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PROCESSES; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			rr_q    <= '0;
			total_q <= '0;
		end else if (cmd.do_clear) begin
			for (int i = 0; i < MAX_PROCESSES; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			rr_q    <= '0;
			total_q <= '0;
		end else if (cmd.do_load) begin
			if (load_ok) begin
				count_q[cur] <= cur_count + CW'(1);
				total_q      <= total_q + TW'(1);
			end
		end else if (cmd.do_serve && best_found_q) begin
			if (fin) begin
				head_q[cur]  <= (cur_head == HW'(MAX_TASKS - 1)) ? '0 : cur_head + HW'(1);
				count_q[cur] <= cur_count - CW'(1);
				total_q      <= total_q - TW'(1);
			end
			if (policy_mode == POLICY_RR) begin
				rr_q <= (best_p_q == PW'(MAX_PROCESSES - 1)) ? '0 : best_p_q + PW'(1);
			end
		end
	end

	// scan counter, candidate pipeline and best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			cand_v_s1    <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			cand_v_s1 <= cmd.scan;
			if (cmd.start) begin
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (cmd.scan && !scan_last) begin
					scan_idx_q <= scan_idx_q + PW'(1);
				end
				if (take) begin
					best_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_p_s1  <= cur;
		cand_nz_s1 <= (cur_count != '0);
		if (take) begin
			best_p_q     <= cand_p_s1;
			best_entry_q <= rd_data;
		end
	end

	// result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (cmd.start) begin
			res_q <= '0;
		end else if (cmd.do_load) begin
			res_q.load_error <= !load_ok;
		end else if (cmd.do_serve && best_found_q) begin
			res_q.slice_valid   <= 1'b1;
			res_q.slice_process <= PID_W'(best_p_q);
			res_q.slice_kind    <= best_entry_q[ENTRY_W-1:CYC_W];
			res_q.slice_time    <= fin ? best_rem : qv;
			res_q.task_finished <= fin;
		end
	end

	always_comb begin
		res          = res_q;
		res.all_done = (total_q == '0);
	end

endmodule

`default_nettype wire
